// ----- sv/npcp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package npcp_pkg;

    localparam int CH_W    = 8;
    localparam int IDX_W   = 6;
    localparam int DIST_W  = 18;
    localparam int FOUND_W = 4;
    localparam int NF_W    = 3;
    localparam int DIV_W   = 7;
    localparam int RND_W   = 32;
    localparam int SQ_W    = 16;

    localparam logic [CH_W-1:0]   RESET_RED     = 8'd255;
    localparam logic [CH_W-1:0]   RESET_GREEN   = 8'd100;
    localparam logic [CH_W-1:0]   RESET_BLUE    = 8'd150;
    localparam logic [DIST_W-1:0] RESET_EXCLUDE = 18'd100;

    localparam logic FUNC_SET    = 1'b0;
    localparam logic FUNC_CHANGE = 1'b1;

    typedef struct packed {
        logic             func;
        logic [CH_W-1:0]  set_red;
        logic [CH_W-1:0]  set_green;
        logic [CH_W-1:0]  set_blue;
        logic [RND_W-1:0] random_word;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_red;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_blue;
        logic [IDX_W-1:0] palette_index;
        logic [NF_W-1:0]  near_found;
    } out_t;

    typedef struct packed {
        logic             idle;
        logic             load;
        logic             dist_en;
        logic [IDX_W-1:0] scan_idx;
        logic             div_init;
        logic             div_step;
        logic             commit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_func;
        logic slot_free;
    } sts_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // Palette ROM; entries past the table read as black.
    function automatic rgb_t rom_rgb(input logic [IDX_W-1:0] idx);
        rgb_t c;
        begin
            unique case (idx)
                6'd0:    c = '{8'd255, 8'd50,  8'd50};
                6'd1:    c = '{8'd220, 8'd20,  8'd60};
                6'd2:    c = '{8'd128, 8'd0,   8'd0};
                6'd3:    c = '{8'd255, 8'd127, 8'd80};
                6'd4:    c = '{8'd250, 8'd128, 8'd114};
                6'd5:    c = '{8'd255, 8'd150, 8'd50};
                6'd6:    c = '{8'd255, 8'd140, 8'd0};
                6'd7:    c = '{8'd255, 8'd255, 8'd50};
                6'd8:    c = '{8'd255, 8'd215, 8'd0};
                6'd9:    c = '{8'd240, 8'd230, 8'd140};
                6'd10:   c = '{8'd50,  8'd255, 8'd50};
                6'd11:   c = '{8'd200, 8'd255, 8'd0};
                6'd12:   c = '{8'd34,  8'd139, 8'd34};
                6'd13:   c = '{8'd128, 8'd128, 8'd0};
                6'd14:   c = '{8'd152, 8'd255, 8'd152};
                6'd15:   c = '{8'd50,  8'd255, 8'd255};
                6'd16:   c = '{8'd0,   8'd128, 8'd128};
                6'd17:   c = '{8'd64,  8'd224, 8'd208};
                6'd18:   c = '{8'd50,  8'd50,  8'd255};
                6'd19:   c = '{8'd0,   8'd0,   8'd128};
                6'd20:   c = '{8'd135, 8'd206, 8'd235};
                6'd21:   c = '{8'd65,  8'd105, 8'd225};
                6'd22:   c = '{8'd200, 8'd50,  8'd255};
                6'd23:   c = '{8'd238, 8'd130, 8'd238};
                6'd24:   c = '{8'd255, 8'd0,   8'd255};
                6'd25:   c = '{8'd230, 8'd190, 8'd255};
                6'd26:   c = '{8'd255, 8'd100, 8'd150};
                6'd27:   c = '{8'd255, 8'd0,   8'd127};
                6'd28:   c = '{8'd255, 8'd218, 8'd185};
                6'd29:   c = '{8'd255, 8'd255, 8'd255};
                6'd30:   c = '{8'd255, 8'd200, 8'd100};
                6'd31:   c = '{8'd200, 8'd200, 8'd255};
                6'd32:   c = '{8'd255, 8'd255, 8'd240};
                default: c = '{8'd0,   8'd0,   8'd0};
            endcase
            return c;
        end
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return SQ_W'(d) * SQ_W'(d);
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/near_palette_color_picker_top.sv -----
// Near palette color picker.
// Input channel in_valid / in_stall / in_data carries one word per command:
// func 0 loads set_red/green/blue as the current color, func 1 moves to a
// palette entry near the current color, picked by random_word. One result
// word per command leaves on out_valid / out_stall / out_data.
// A set word goes from the accepting state straight to emit; a change word
// first runs the palette scan (one ROM entry a cycle), a drain state, the
// divider load and the 32-step remainder unit. In emit the result is handed
// to the output register once the output slot is free. The block takes one
// command at a time; the next word is taken in the cycle after the result
// is handed to the output register.
// The output register lets a new word be taken while a result waits; with
// out_stall held the block finishes the next command and holds it.
// Reset (rst_n low, asynchronous) sets the color to 255,100,150 and the
// exclusion distance to 100. cfg_we/cfg_wdata write the exclusion distance;
// write it only while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none

module near_palette_color_picker_top #(
    parameter int PALETTE_SIZE = 33,
    parameter int NEAR_COUNT   = 5
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  npcp_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  wire                           out_stall,
    output npcp_pkg::out_t                out_data,
    input  wire                           cfg_we,
    input  wire  [npcp_pkg::DIST_W-1:0]   cfg_wdata
);

    npcp_pkg::cmd_t  cmd;
    npcp_pkg::sts_t  sts;
    npcp_pkg::out_t  result;
    npcp_pkg::out_t  out_data_reg;
    logic            out_valid_reg, out_valid_next;

    // the slot is free when empty or being drained this cycle
    assign sts.in_valid  = in_valid;
    assign sts.in_func   = in_data.func;
    assign sts.slot_free = !out_valid_reg || !out_stall;

    // hold off new words while a command is in flight
    assign in_stall = !cmd.idle;

    npcp_ctrl #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    npcp_dpath #(
        .PALETTE_SIZE (PALETTE_SIZE),
        .NEAR_COUNT   (NEAR_COUNT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    // load on commit, drop once taken, otherwise hold
    assign out_valid_next = cmd.commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // one command at a time: an accepted word is never followed directly
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while busy");

    // a commit never lands on a result still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !cmd.commit)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- sv/npcp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module npcp_ctrl #(
    parameter int PALETTE_SIZE = 33
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  npcp_pkg::sts_t      sts,
    output npcp_pkg::cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_DRAIN    = 6'b000100,
        ST_DIV_INIT = 6'b001000,
        ST_DIV      = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    localparam logic [npcp_pkg::IDX_W-1:0] SCAN_LAST = npcp_pkg::IDX_W'(PALETTE_SIZE - 1);
    localparam logic [npcp_pkg::IDX_W-1:0] DIV_LAST  = npcp_pkg::IDX_W'(npcp_pkg::RND_W - 1);

    state_t                      state_reg, state_next;
    logic [npcp_pkg::IDX_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.scan_idx = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = (sts.in_func == npcp_pkg::FUNC_SET) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.dist_en = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // a direct set goes straight to the result
    a_set_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && sts.in_func == npcp_pkg::FUNC_SET |=> state_reg == ST_EMIT)
        else $error("set word did not go to emit");

    // the list is settled before the divider loads
    a_drain_first: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_INIT |-> $past(state_reg == ST_DRAIN))
        else $error("divider loaded before the list settled");

endmodule

`default_nettype wire

// ----- sv/npcp_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module npcp_dpath #(
    parameter int PALETTE_SIZE = 33,
    parameter int NEAR_COUNT   = 5
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  npcp_pkg::cmd_t                     cmd,
    input  npcp_pkg::in_t                      in_data,
    input  wire                                cfg_we,
    input  wire  [npcp_pkg::DIST_W-1:0]        cfg_wdata,
    output npcp_pkg::out_t                     result
);

    localparam int LW = (NEAR_COUNT > 1) ? $clog2(NEAR_COUNT) : 1;

    npcp_pkg::in_t                   item_reg;
    npcp_pkg::rgb_t                  cur_reg;
    logic [npcp_pkg::DIST_W-1:0]     excl_reg;

    logic [npcp_pkg::DIST_W-1:0]     d_reg, d_next;
    logic [npcp_pkg::IDX_W-1:0]      d_idx_reg;
    logic                            d_valid_reg;

    logic [npcp_pkg::DIST_W-1:0]     dist_reg [NEAR_COUNT];
    logic [npcp_pkg::IDX_W-1:0]      pidx_reg [NEAR_COUNT];
    logic [npcp_pkg::DIST_W-1:0]     dist_in  [NEAR_COUNT];
    logic [npcp_pkg::IDX_W-1:0]      pidx_in  [NEAR_COUNT];
    logic [NEAR_COUNT-1:0]           lt;
    logic [npcp_pkg::FOUND_W-1:0]    found_reg;
    logic                            insert;

    logic [npcp_pkg::DIV_W-1:0]      divisor_reg;
    logic [npcp_pkg::RND_W-1:0]      dividend_reg;
    logic [npcp_pkg::IDX_W-1:0]      rem_reg, rem_next;
    logic [npcp_pkg::DIV_W-1:0]      shifted;

    npcp_pkg::rgb_t                  scan_rgb;
    npcp_pkg::rgb_t                  pick_rgb;
    logic [npcp_pkg::IDX_W-1:0]      chosen;

    // distance of the scanned entry to the current color
    always_comb
    begin
        scan_rgb = npcp_pkg::rom_rgb(cmd.scan_idx);
        d_next = npcp_pkg::DIST_W'(npcp_pkg::sq_diff(scan_rgb.red,   cur_reg.red))
               + npcp_pkg::DIST_W'(npcp_pkg::sq_diff(scan_rgb.green, cur_reg.green))
               + npcp_pkg::DIST_W'(npcp_pkg::sq_diff(scan_rgb.blue,  cur_reg.blue));
    end

    // lt is a thermometer over the sorted list: set from the insert slot on
    for (genvar j = 0; j < NEAR_COUNT; j++)
    begin : g_slot
        assign lt[j] = (npcp_pkg::FOUND_W'(j) >= found_reg) || (d_reg < dist_reg[j]);
        if (j == 0)
        begin : g_head
            assign dist_in[j] = d_reg;
            assign pidx_in[j] = d_idx_reg;
        end
        else
        begin : g_tail
            assign dist_in[j] = lt[j-1] ? dist_reg[j-1] : d_reg;
            assign pidx_in[j] = lt[j-1] ? pidx_reg[j-1] : d_idx_reg;
        end
    end

    assign insert = d_valid_reg && (d_reg >= excl_reg) && lt[NEAR_COUNT-1];

    // one dividend bit shifted into the remainder per step
    always_comb
    begin
        shifted  = {rem_reg, dividend_reg[npcp_pkg::RND_W-1]};
        rem_next = (shifted >= divisor_reg) ? npcp_pkg::IDX_W'(shifted - divisor_reg)
                                            : shifted[npcp_pkg::IDX_W-1:0];
    end

    always_comb
    begin
        chosen   = (found_reg != '0) ? pidx_reg[rem_reg[LW-1:0]] : rem_reg;
        pick_rgb = npcp_pkg::rom_rgb(chosen);
        if (item_reg.func == npcp_pkg::FUNC_SET)
        begin
            result.out_red       = item_reg.set_red;
            result.out_green     = item_reg.set_green;
            result.out_blue      = item_reg.set_blue;
            result.palette_index = '0;
            result.near_found    = '0;
        end
        else
        begin
            result.out_red       = pick_rgb.red;
            result.out_green     = pick_rgb.green;
            result.out_blue      = pick_rgb.blue;
            result.palette_index = chosen;
            result.near_found    = found_reg[npcp_pkg::NF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '{npcp_pkg::RESET_RED, npcp_pkg::RESET_GREEN,
                             npcp_pkg::RESET_BLUE};
            excl_reg    <= npcp_pkg::RESET_EXCLUDE;
            d_valid_reg <= 1'b0;
            found_reg   <= '0;
        end
        else
        begin
            d_valid_reg <= cmd.dist_en;
            if (cfg_we)
            begin
                excl_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                cur_reg <= '{result.out_red, result.out_green, result.out_blue};
            end
            if (cmd.load)
            begin
                found_reg <= '0;
            end
            else if (insert && found_reg != npcp_pkg::FOUND_W'(NEAR_COUNT))
            begin
                found_reg <= found_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.dist_en)
        begin
            d_reg     <= d_next;
            d_idx_reg <= cmd.scan_idx;
        end
        for (int j = 0; j < NEAR_COUNT; j++)
        begin
            if (insert && lt[j])
            begin
                dist_reg[j] <= dist_in[j];
                pidx_reg[j] <= pidx_in[j];
            end
        end
        if (cmd.div_init)
        begin
            dividend_reg <= item_reg.random_word;
            rem_reg      <= '0;
            divisor_reg  <= (found_reg == '0) ? npcp_pkg::DIV_W'(PALETTE_SIZE)
                                              : npcp_pkg::DIV_W'(found_reg);
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[npcp_pkg::RND_W-2:0], 1'b0};
            rem_reg      <= rem_next;
        end
    end

    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= npcp_pkg::FOUND_W'(NEAR_COUNT))
        else $error("near list overfilled");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_step) |-> rem_reg < npcp_pkg::DIV_W'(divisor_reg))
        else $error("remainder not below divisor");

    a_list_order: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg == npcp_pkg::FOUND_W'(NEAR_COUNT) |-> dist_reg[0] <= dist_reg[NEAR_COUNT-1])
        else $error("near list out of order");

endmodule

`default_nettype wire
